// File: rtl/vbi_pkg.sv
package vbi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int STEP_W        = 5;

  // Request codes.
  localparam logic [2:0] REQ_FORCE = 3'd0;
  localparam logic [2:0] REQ_INTEG = 3'd1;
  localparam logic [2:0] REQ_CENTR = 3'd2;
  localparam logic [2:0] REQ_SETV  = 3'd3;
  localparam logic [2:0] REQ_SETW  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IMASS = 2'd0;
  localparam logic [1:0] CFG_IINRT = 2'd1;
  localparam logic [1:0] CFG_AFRIC = 2'd2;
  localparam logic [1:0] CFG_BTS   = 2'd3;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL} op_e;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WB, S_DONE} state_e;

  typedef enum logic [2:0] {
    PRG_FORCE, PRG_INTEG, PRG_CABS, PRG_CREL, PRG_SETV, PRG_SETW, PRG_NONE
  } prog_e;

  // Operand and destination selection.
  typedef enum logic [4:0] {
    R_ZERO, R_ONE, R_TA, R_TB, R_DT2, R_FA,
    R_POSX, R_POSY, R_PREVX, R_PREVY, R_ANG, R_ANGP,
    R_FRCX, R_FRCY, R_TRQ, R_VELX, R_VELY, R_AVEL,
    R_VECX, R_VECY, R_PTX, R_PTY, R_SPIN, R_ST, R_GTS, R_CORR,
    R_IMASS, R_IINRT, R_AFRIC, R_BTS
  } sel_e;

  typedef struct packed {
    op_e  op;
    sel_e a;
    sel_e b;
    sel_e dst;
    logic last;
  } uop_t;

  typedef struct packed {
    logic go;
    op_e  op;
  } alu_req_t;

  function automatic uop_t mk(op_e op, sel_e a, sel_e b, sel_e dst, logic last);
    uop_t u;
    u.op   = op;
    u.a    = a;
    u.b    = b;
    u.dst  = dst;
    u.last = last;
    return u;
  endfunction

  // Micro-programs, one per request kind.
  function automatic uop_t ucode(prog_e prog, logic [STEP_W-1:0] step);
    uop_t u;
    u = mk(OP_ADD, R_ZERO, R_ZERO, R_ZERO, 1'b1);
    case (prog)
      PRG_FORCE: begin
        case (step)
          5'd0: u = mk(OP_SUB, R_PTX,  R_POSX, R_TA,   1'b0);
          5'd1: u = mk(OP_SUB, R_PTY,  R_POSY, R_TB,   1'b0);
          5'd2: u = mk(OP_ADD, R_FRCX, R_VECX, R_FRCX, 1'b0);
          5'd3: u = mk(OP_ADD, R_FRCY, R_VECY, R_FRCY, 1'b0);
          5'd4: u = mk(OP_MUL, R_TA,   R_VECY, R_TA,   1'b0);
          5'd5: u = mk(OP_MUL, R_TB,   R_VECX, R_TB,   1'b0);
          5'd6: u = mk(OP_SUB, R_TA,   R_TB,   R_TA,   1'b0);
          default: u = mk(OP_ADD, R_TRQ, R_TA, R_TRQ, 1'b1);
        endcase
      end
      PRG_INTEG: begin
        case (step)
          5'd0:  u = mk(OP_MUL, R_ST,    R_GTS,   R_TA,    1'b0);
          5'd1:  u = mk(OP_MUL, R_TA,    R_BTS,   R_TA,    1'b0);
          5'd2:  u = mk(OP_MUL, R_TA,    R_TA,    R_DT2,   1'b0);
          5'd3:  u = mk(OP_MUL, R_AFRIC, R_GTS,   R_TA,    1'b0);
          5'd4:  u = mk(OP_MUL, R_TA,    R_BTS,   R_TA,    1'b0);
          5'd5:  u = mk(OP_SUB, R_ONE,   R_TA,    R_FA,    1'b0);
          5'd6:  u = mk(OP_SUB, R_POSX,  R_PREVX, R_TA,    1'b0);
          5'd7:  u = mk(OP_MUL, R_TA,    R_FA,    R_TA,    1'b0);
          5'd8:  u = mk(OP_MUL, R_TA,    R_CORR,  R_TA,    1'b0);
          5'd9:  u = mk(OP_MUL, R_FRCX,  R_IMASS, R_TB,    1'b0);
          5'd10: u = mk(OP_MUL, R_TB,    R_DT2,   R_TB,    1'b0);
          5'd11: u = mk(OP_ADD, R_TA,    R_TB,    R_VELX,  1'b0);
          5'd12: u = mk(OP_ADD, R_POSX,  R_ZERO,  R_PREVX, 1'b0);
          5'd13: u = mk(OP_ADD, R_POSX,  R_VELX,  R_POSX,  1'b0);
          5'd14: u = mk(OP_SUB, R_POSY,  R_PREVY, R_TA,    1'b0);
          5'd15: u = mk(OP_MUL, R_TA,    R_FA,    R_TA,    1'b0);
          5'd16: u = mk(OP_MUL, R_TA,    R_CORR,  R_TA,    1'b0);
          5'd17: u = mk(OP_MUL, R_FRCY,  R_IMASS, R_TB,    1'b0);
          5'd18: u = mk(OP_MUL, R_TB,    R_DT2,   R_TB,    1'b0);
          5'd19: u = mk(OP_ADD, R_TA,    R_TB,    R_VELY,  1'b0);
          5'd20: u = mk(OP_ADD, R_POSY,  R_ZERO,  R_PREVY, 1'b0);
          5'd21: u = mk(OP_ADD, R_POSY,  R_VELY,  R_POSY,  1'b0);
          5'd22: u = mk(OP_SUB, R_ANG,   R_ANGP,  R_TA,    1'b0);
          5'd23: u = mk(OP_MUL, R_TA,    R_FA,    R_TA,    1'b0);
          5'd24: u = mk(OP_MUL, R_TA,    R_CORR,  R_TA,    1'b0);
          5'd25: u = mk(OP_MUL, R_TRQ,   R_IINRT, R_TB,    1'b0);
          5'd26: u = mk(OP_MUL, R_TB,    R_DT2,   R_TB,    1'b0);
          5'd27: u = mk(OP_ADD, R_TA,    R_TB,    R_AVEL,  1'b0);
          5'd28: u = mk(OP_ADD, R_ANG,   R_ZERO,  R_ANGP,  1'b0);
          default: u = mk(OP_ADD, R_ANG, R_AVEL,  R_ANG,   1'b1);
        endcase
      end
      PRG_CABS: begin
        case (step)
          5'd0: u = mk(OP_SUB, R_POSX, R_PREVX, R_TA,    1'b0);
          5'd1: u = mk(OP_SUB, R_VECX, R_TA,    R_PREVX, 1'b0);
          5'd2: u = mk(OP_ADD, R_VECX, R_ZERO,  R_POSX,  1'b0);
          5'd3: u = mk(OP_SUB, R_POSY, R_PREVY, R_TA,    1'b0);
          5'd4: u = mk(OP_SUB, R_VECY, R_TA,    R_PREVY, 1'b0);
          default: u = mk(OP_ADD, R_VECY, R_ZERO, R_POSY, 1'b1);
        endcase
      end
      PRG_CREL: begin
        case (step)
          5'd0: u = mk(OP_ADD, R_PREVX, R_VECX, R_PREVX, 1'b0);
          5'd1: u = mk(OP_ADD, R_POSX,  R_VECX, R_POSX,  1'b0);
          5'd2: u = mk(OP_ADD, R_PREVY, R_VECY, R_PREVY, 1'b0);
          default: u = mk(OP_ADD, R_POSY, R_VECY, R_POSY, 1'b1);
        endcase
      end
      PRG_SETV: begin
        case (step)
          5'd0: u = mk(OP_SUB, R_POSX, R_VECX, R_PREVX, 1'b0);
          5'd1: u = mk(OP_ADD, R_VECX, R_ZERO, R_VELX,  1'b0);
          5'd2: u = mk(OP_SUB, R_POSY, R_VECY, R_PREVY, 1'b0);
          default: u = mk(OP_ADD, R_VECY, R_ZERO, R_VELY, 1'b1);
        endcase
      end
      PRG_SETW: begin
        case (step)
          5'd0: u = mk(OP_SUB, R_ANG, R_SPIN, R_ANGP, 1'b0);
          default: u = mk(OP_ADD, R_SPIN, R_ZERO, R_AVEL, 1'b1);
        endcase
      end
      default: u = mk(OP_ADD, R_ZERO, R_ZERO, R_ZERO, 1'b1);
    endcase
    return u;
  endfunction

endpackage

// File: rtl/verlet_body_integrator_unit.sv
// Each request runs a micro-program of N micro-operations on the shared unit,
// each one issued and then written back in turn: N is 8 for apply force, 30 for
// integrate, 6 or 4 for set centre, 4 for set velocity, 2 for set angular velocity
// and none for an unknown request. No new item is taken until the result of the
// last one has been handed over to the output register.
// Reset (asynchronous, active low) zeroes the body state and loads defaults.
module verlet_body_integrator_unit #(
  parameter int FRACTION_BITS = vbi_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic               relative_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] spin_rate_i,
  input  logic [30:0]        step_time_i,
  input  logic [30:0]        global_time_scale_i,
  input  logic [30:0]        correction_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] heading_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] ang_vel_o,
  output logic [30:0]        ang_speed_o,
  output logic               saturated_o,
  // Configuration writes.
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i
);
  import vbi_pkg::*;

  // Unity and the default friction (about 0.001) in the chosen fixed-point format.
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;
  localparam int AFRIC_RST_INT = (66 << FRACTION_BITS) >> 16;
  localparam logic [16:0] AFRIC_RST = 17'(AFRIC_RST_INT);
  localparam logic [30:0] BTS_RST = 31'(1) << FRACTION_BITS;

  // Configuration registers.
  logic [30:0] imass_q, iinrt_q, bts_q;
  logic [16:0] afric_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imass_q <= '0;
      iinrt_q <= '0;
      afric_q <= AFRIC_RST;
      bts_q   <= BTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMASS: imass_q <= cfg_data_i;
        CFG_IINRT: iinrt_q <= cfg_data_i;
        CFG_AFRIC: afric_q <= cfg_data_i[16:0];
        CFG_BTS:   bts_q   <= cfg_data_i;
        default:   imass_q <= imass_q;
      endcase
    end
  end

  // Sequencer state.
  state_e            state_q, state_d;
  prog_e             prog_q, prog_sel;
  logic [STEP_W-1:0] step_q, step_d;
  logic              sat_q;
  uop_t              uop;
  logic              in_xfer, out_xfer, out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_o && !out_stall_i;
  assign uop        = ucode(prog_q, step_q);

  // Request decode into a micro-program.
  always_comb begin
    case (req_type_i)
      REQ_FORCE: prog_sel = PRG_FORCE;
      REQ_INTEG: prog_sel = PRG_INTEG;
      REQ_CENTR: prog_sel = relative_i ? PRG_CREL : PRG_CABS;
      REQ_SETV:  prog_sel = PRG_SETV;
      REQ_SETW:  prog_sel = PRG_SETW;
      default:   prog_sel = PRG_NONE;
    endcase
  end

  // The input payload is held for the whole item.
  logic signed [31:0] vecx_q, vecy_q, ptx_q, pty_q, spin_q;
  logic [30:0]        st_q, gts_q, corr_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      vecx_q <= vec_x_i;
      vecy_q <= vec_y_i;
      ptx_q  <= point_x_i;
      pty_q  <= point_y_i;
      spin_q <= spin_rate_i;
      st_q   <= step_time_i;
      gts_q  <= global_time_scale_i;
      corr_q <= correction_i;
    end
  end

  // Body state and scratch values.
  logic signed [31:0] posx_q, posy_q, prevx_q, prevy_q, ang_q, angp_q;
  logic signed [31:0] frcx_q, frcy_q, trq_q, velx_q, vely_q, avel_q;
  logic signed [31:0] ta_q, tb_q, dt2_q, fa_q;

  // Operand selection for the shared unit.
  function automatic logic signed [31:0] pick(sel_e s);
    logic signed [31:0] v;
    case (s)
      R_ONE:   v = ONE;
      R_TA:    v = ta_q;
      R_TB:    v = tb_q;
      R_DT2:   v = dt2_q;
      R_FA:    v = fa_q;
      R_POSX:  v = posx_q;
      R_POSY:  v = posy_q;
      R_PREVX: v = prevx_q;
      R_PREVY: v = prevy_q;
      R_ANG:   v = ang_q;
      R_ANGP:  v = angp_q;
      R_FRCX:  v = frcx_q;
      R_FRCY:  v = frcy_q;
      R_TRQ:   v = trq_q;
      R_VELX:  v = velx_q;
      R_VELY:  v = vely_q;
      R_AVEL:  v = avel_q;
      R_VECX:  v = vecx_q;
      R_VECY:  v = vecy_q;
      R_PTX:   v = ptx_q;
      R_PTY:   v = pty_q;
      R_SPIN:  v = spin_q;
      R_ST:    v = {1'b0, st_q};
      R_GTS:   v = {1'b0, gts_q};
      R_CORR:  v = {1'b0, corr_q};
      R_IMASS: v = {1'b0, imass_q};
      R_IINRT: v = {1'b0, iinrt_q};
      R_AFRIC: v = {15'd0, afric_q};
      R_BTS:   v = {1'b0, bts_q};
      default: v = '0;
    endcase
    return v;
  endfunction

  alu_req_t           alu_req;
  logic signed [31:0] alu_res;
  logic               alu_sat;

  assign alu_req.go = (state_q == S_ISSUE);
  assign alu_req.op = uop.op;

  vbi_alu #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_alu (
    .clk_i (clk_i),
    .req_i (alu_req),
    .a_i   (pick(uop.a)),
    .b_i   (pick(uop.b)),
    .res_o (alu_res),
    .sat_o (alu_sat)
  );

  // Next state: issue a micro-operation, write it back, repeat until the
  // last one, then hand the state over to the output register.
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          step_d  = '0;
          state_d = (prog_sel == PRG_NONE) ? S_DONE : S_ISSUE;
        end
      end
      S_ISSUE: state_d = S_WB;
      S_WB: begin
        if (uop.last) begin
          state_d = S_DONE;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = S_ISSUE;
        end
      end
      S_DONE: begin
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      prog_q  <= PRG_NONE;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (in_xfer) begin
        prog_q <= prog_sel;
        sat_q  <= 1'b0;
      end else if (state_q == S_WB && alu_sat) begin
        sat_q <= 1'b1;
      end
    end
  end

  // Write-back of the unit's result.
  logic wb;
  assign wb = (state_q == S_WB);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      posx_q  <= '0;
      posy_q  <= '0;
      prevx_q <= '0;
      prevy_q <= '0;
      ang_q   <= '0;
      angp_q  <= '0;
      frcx_q  <= '0;
      frcy_q  <= '0;
      trq_q   <= '0;
      velx_q  <= '0;
      vely_q  <= '0;
      avel_q  <= '0;
    end else if (wb) begin
      case (uop.dst)
        R_POSX:  posx_q  <= alu_res;
        R_POSY:  posy_q  <= alu_res;
        R_PREVX: prevx_q <= alu_res;
        R_PREVY: prevy_q <= alu_res;
        R_ANG:   ang_q   <= alu_res;
        R_ANGP:  angp_q  <= alu_res;
        R_FRCX:  frcx_q  <= alu_res;
        R_FRCY:  frcy_q  <= alu_res;
        R_TRQ:   trq_q   <= alu_res;
        R_VELX:  velx_q  <= alu_res;
        R_VELY:  vely_q  <= alu_res;
        R_AVEL:  avel_q  <= alu_res;
        default: posx_q  <= posx_q;
      endcase
    end
  end

  // Scratch values need no reset: every program writes them before reading.
  always_ff @(posedge clk_i) begin
    if (wb) begin
      case (uop.dst)
        R_TA:    ta_q  <= alu_res;
        R_TB:    tb_q  <= alu_res;
        R_DT2:   dt2_q <= alu_res;
        R_FA:    fa_q  <= alu_res;
        default: ta_q  <= ta_q;
      endcase
    end
  end

  // Absolute angular velocity; only the most negative value clips.
  logic        avel_min;
  logic [31:0] avel_neg;
  logic [30:0] speed;

  assign avel_min = (avel_q == 32'sh8000_0000);
  assign avel_neg = 32'(-avel_q);
  assign speed    = avel_min ? 31'h7FFF_FFFF :
                    (avel_q[31] ? avel_neg[30:0] : avel_q[30:0]);

  // Output register: it parts the result side from the sequencer, so a new
  // item can be taken while a result still waits for its transfer.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_x_o     <= posx_q;
      pos_y_o     <= posy_q;
      heading_o   <= ang_q;
      vel_x_o     <= velx_q;
      vel_y_o     <= vely_q;
      ang_vel_o   <= avel_q;
      ang_speed_o <= speed;
      saturated_o <= sat_q | avel_min;
    end
  end

  assign out_valid_o = out_valid_q;

  // The step counter never runs past the longest program.
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE) |-> (step_q < STEP_W'(30)))
    else $error("step counter beyond the longest micro-program");

  // The last write-back always leads to the hand-over state.
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && uop.last) |=> (state_q == S_DONE))
    else $error("last micro-operation did not finish the item");

  // A new result appears only from the hand-over state.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside the hand-over state");

  // The clip flag starts clear for every item.
  a_sat_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !sat_q)
    else $error("clip flag not cleared at the start of an item");

endmodule

// File: rtl/vbi_alu.sv
module vbi_alu #(
  parameter int FRACTION_BITS = vbi_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  vbi_pkg::alu_req_t  req_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] res_o,
  output logic               sat_o
);
  import vbi_pkg::*;

  // First stage: exact product, sum or difference. Second stage: scale and clip.
  logic signed [63:0] acc_q;
  logic               mul_q;
  logic signed [63:0] scaled;

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      mul_q <= (req_i.op == OP_MUL);
      case (req_i.op)
        OP_MUL:  acc_q <= 64'(a_i) * 64'(b_i);
        OP_SUB:  acc_q <= 64'(a_i) - 64'(b_i);
        default: acc_q <= 64'(a_i) + 64'(b_i);
      endcase
    end
  end

  assign scaled = mul_q ? (acc_q >>> FRACTION_BITS) : acc_q;

  always_comb begin
    sat_o = (scaled[63:31] != {33{1'b0}}) && (scaled[63:31] != {33{1'b1}});
    if (sat_o) begin
      res_o = scaled[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      res_o = scaled[31:0];
    end
  end

endmodule
